>>> hw/rtl/bounded_deque_with_positional_edit_assert.svh
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// shared helpers for concurrent checks, clocked on clock, reset active high
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_EDIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_EDIT_ASSERT_SVH

// check that is switched off while reset is high
`define BDQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also runs through reset
`define BDQ_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hw/rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// sizes, operation and status codes and control types of the bounded deque
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int POS_W  = 5;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_QUERY      = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_HOLD = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic exec;
   } ctl_cmd_type;

endpackage

>>> hw/rtl/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq channel interfaces
// valid/ready channels for request and response words of the bounded deque
// ----------------------------------------------------------------------------
interface bdq_req_if;
   logic                                valid;
   logic                                ready;
   logic [bdq_pkg::KIND_W-1:0]          kind;
   logic [bdq_pkg::POS_W-1:0]           position;
   logic signed [bdq_pkg::DATA_W-1:0]   value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface bdq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bdq_pkg::DATA_W-1:0]   front_value;
   logic signed [bdq_pkg::DATA_W-1:0]   back_value;
   logic [bdq_pkg::CNT_W-1:0]           count;
   logic                                is_empty;
   logic [bdq_pkg::STAT_W-1:0]          status;

   modport source (output valid, output front_value, output back_value, output count,
                   output is_empty, output status, input ready);
   modport sink   (input valid, input front_value, input back_value, input count,
                   input is_empty, input status, output ready);
endinterface

>>> hw/rtl/bdq_controller.sv
// ----------------------------------------------------------------------------
// bdq_controller
// tracks whether a response word is held and issues the execute command
// ----------------------------------------------------------------------------
module bdq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bdq_pkg::ctl_cmd_type  cmd
);

   bdq_pkg::ctl_state_type state_ff;
   bdq_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         bdq_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = bdq_pkg::CTL_HOLD;
            end
         end
         bdq_pkg::CTL_HOLD: begin
            rsp_valid = 1'b1;
            // next word may enter as the held one leaves
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.exec = 1'b1;
               end else begin
                  state_in = bdq_pkg::CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = bdq_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/bdq_datapath.sv
// ----------------------------------------------------------------------------
// bdq_datapath
// row of entry cells that shift or hold in parallel, occupancy and status
// ----------------------------------------------------------------------------
module bdq_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  bdq_pkg::ctl_cmd_type               cmd,
   input  logic [bdq_pkg::KIND_W-1:0]         kind,
   input  logic [bdq_pkg::POS_W-1:0]          position,
   input  logic signed [bdq_pkg::DATA_W-1:0]  value,
   output logic signed [bdq_pkg::DATA_W-1:0]  front_value,
   output logic signed [bdq_pkg::DATA_W-1:0]  back_value,
   output logic [bdq_pkg::CNT_W-1:0]          count,
   output logic                               is_empty,
   output logic [bdq_pkg::STAT_W-1:0]         status
);

   logic signed [bdq_pkg::DATA_W-1:0] cells_ff [bdq_pkg::DEPTH];
   logic signed [bdq_pkg::DATA_W-1:0] cells_in [bdq_pkg::DEPTH];
   logic [bdq_pkg::CNT_W-1:0]         occ_ff;
   logic [bdq_pkg::CNT_W-1:0]         occ_in;
   bdq_pkg::status_type               status_ff;
   bdq_pkg::status_type               status_in;

   bdq_pkg::op_type                   op;
   logic [bdq_pkg::CMP_W-1:0]         pos_cmp;
   logic [bdq_pkg::CMP_W-1:0]         occ_cmp;
   logic                              full;
   logic                              empty_now;
   logic                              do_ins;
   logic                              do_era;
   logic [bdq_pkg::CNT_W-1:0]         at;
   logic [bdq_pkg::CNT_W-1:0]         last_cnt;

   assign op        = bdq_pkg::op_type'(kind);
   assign pos_cmp   = bdq_pkg::CMP_W'(position);
   assign occ_cmp   = bdq_pkg::CMP_W'(occ_ff);
   assign full      = (occ_ff == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
   assign empty_now = (occ_ff == '0);

   // operation decode
   always_comb begin
      status_in = bdq_pkg::ST_OK;
      occ_in    = occ_ff;
      do_ins    = 1'b0;
      do_era    = 1'b0;
      at        = '0;
      case (op)
         bdq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               at     = occ_ff;
               occ_in = occ_ff + bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               occ_in = occ_ff + bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (empty_now) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               do_era = 1'b1;
               occ_in = occ_ff - bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            if (empty_now) begin
               status_in = bdq_pkg::ST_EMPTY;
            end else begin
               occ_in = occ_ff - bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::OP_INSERT: begin
            if (pos_cmp > occ_cmp) begin
               status_in = bdq_pkg::ST_BADPOS;
            end else if (full) begin
               status_in = bdq_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               at     = bdq_pkg::CNT_W'(pos_cmp);
               occ_in = occ_ff + bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::OP_ERASE: begin
            if (pos_cmp >= occ_cmp) begin
               status_in = bdq_pkg::ST_BADPOS;
            end else begin
               do_era = 1'b1;
               at     = bdq_pkg::CNT_W'(pos_cmp);
               occ_in = occ_ff - bdq_pkg::CNT_W'(1);
            end
         end
         bdq_pkg::OP_CLEAR: begin
            occ_in = '0;
         end
         default: begin
         end
      endcase
   end

   // each cell takes its neighbour, the new word, or holds
   for (genvar g = 0; g < bdq_pkg::DEPTH; g++) begin : g_cell
      always_comb begin
         cells_in[g] = cells_ff[g];
         if (do_ins) begin
            if (bdq_pkg::CNT_W'(g) == at) begin
               cells_in[g] = value;
            end else if (bdq_pkg::CNT_W'(g) > at) begin
               cells_in[g] = cells_ff[(g > 0) ? g - 1 : 0];
            end
         end else if (do_era) begin
            if ((bdq_pkg::CNT_W'(g) >= at) && (g < bdq_pkg::DEPTH - 1)) begin
               cells_in[g] = cells_ff[(g < bdq_pkg::DEPTH - 1) ? g + 1 : g];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cells_ff  <= cells_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.exec) begin
         occ_ff <= occ_in;
      end
   end

   // response read straight from the stored state
   assign last_cnt    = occ_ff - bdq_pkg::CNT_W'(1);
   assign front_value = empty_now ? '1 : cells_ff[0];
   assign back_value  = empty_now ? '1 : cells_ff[last_cnt[bdq_pkg::IDX_W-1:0]];
   assign count       = occ_ff;
   assign is_empty    = empty_now;
   assign status      = status_ff;

endmodule

>>> hw/rtl/bounded_deque_with_positional_edit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_edit
// bounded double-ended queue of signed words with insert and erase by index
// ----------------------------------------------------------------------------
// each request word carries one operation (push or pop at either end, insert
// or erase at a position counted from the front, clear, or query) and returns
// exactly one response word with the front, back, count, empty flag and a
// status; front and back read -1 when empty, a removal from empty, a bad index
// or a push or insert into a full queue is flagged and leaves the queue
// untouched; the entry cells shift or hold in parallel, so with the response
// side taking every word a request is accepted in every cycle, the held
// response register being the only limit
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_edit (
   input  logic       clock,
   input  logic       reset,
   bdq_req_if.sink    req_ch,
   bdq_rsp_if.source  rsp_ch
);

   bdq_pkg::ctl_cmd_type cmd;

   // handshake control: holds one response word, refills as it drains
   bdq_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // entry cells, occupancy and status register
   bdq_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .kind        (req_ch.kind),
      .position    (req_ch.position),
      .value       (req_ch.value),
      .front_value (rsp_ch.front_value),
      .back_value  (rsp_ch.back_value),
      .count       (rsp_ch.count),
      .is_empty    (rsp_ch.is_empty),
      .status      (rsp_ch.status)
   );

endmodule

>>> hw/rtl/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks on the bounded deque, bound to the top level
// ----------------------------------------------------------------------------
`include "bounded_deque_with_positional_edit_assert.svh"

module bdq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [bdq_pkg::DATA_W-1:0]  rsp_front_value,
   input logic signed [bdq_pkg::DATA_W-1:0]  rsp_back_value,
   input logic [bdq_pkg::CNT_W-1:0]          rsp_count,
   input logic                               rsp_is_empty
);

   `BDQ_ASSERT_RST(a_no_rsp_after_reset, reset |=> !rsp_valid, "response word right after reset")
   `BDQ_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid, "response word dropped")
   `BDQ_ASSERT(a_empty_flag, rsp_valid |-> (rsp_is_empty == (rsp_count == '0)), "empty flag mismatch")
   `BDQ_ASSERT(a_empty_reads, rsp_valid && rsp_is_empty |-> (rsp_front_value == -32'sd1) && (rsp_back_value == -32'sd1), "empty queue ends not -1")
   `BDQ_ASSERT(a_count_bound, rsp_valid |-> (rsp_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH)), "count beyond depth")

endmodule

bind bounded_deque_with_positional_edit bdq_checker u_bdq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_front_value (rsp_ch.front_value),
   .rsp_back_value  (rsp_ch.back_value),
   .rsp_count       (rsp_ch.count),
   .rsp_is_empty    (rsp_ch.is_empty)
);
